// ===== design/srt_pkg.sv =====
// Package for the sorted record table: item types, opcodes, status codes,
// key selectors, controller states and datapath commands. No dependencies.
package srt_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int TITLE_CHARS_DEF = 32;
    localparam int NAME_CHARS_DEF  = 32;

    localparam logic [2:0] OP_CLEAR       = 3'd0;
    localparam logic [2:0] OP_STAGE_TITLE = 3'd1;
    localparam logic [2:0] OP_STAGE_NAME  = 3'd2;
    localparam logic [2:0] OP_STAGE_YEAR  = 3'd3;
    localparam logic [2:0] OP_INSERT      = 3'd4;
    localparam logic [2:0] OP_SEARCH      = 3'd5;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [1:0] KEY_TITLE = 2'd0;
    localparam logic [1:0] KEY_NAME  = 2'd1;
    localparam logic [1:0] KEY_YEAR  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  char_position;
        logic [7:0]  char_value;
        logic [15:0] year_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] found_index;
        logic [6:0] entry_total;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_CHK,
        S_SCH_CHK,
        S_CMP_RD,
        S_CMP_EV,
        S_MOVE_CHK,
        S_MOVE_RD,
        S_MOVE_WR,
        S_STORE,
        S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        C_NONE,
        C_CAPTURE,
        C_SIMPLE,
        C_SCAN_INIT,
        C_SCAN_NEXT,
        C_SCH_INIT,
        C_SCH_MID,
        C_SCH_LEFT,
        C_SCH_RIGHT,
        C_CMP_READ,
        C_CHAR_NEXT,
        C_MOVE_INIT,
        C_MOVE_READ,
        C_MOVE_WRITE,
        C_STORE_WRITE,
        C_SET_FULL,
        C_SET_MISS,
        C_SET_HIT
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       scan_end;
        logic       range_empty;
        logic       cmp_done;
        logic       cmp_lt;
        logic       cmp_eq;
        logic       move_done;
        logic       char_last;
    } t_dp_stat;

endpackage

// ===== design/sorted_record_table.sv =====
// Top level of the sorted record table: controller, datapath and output register.
// Depends on srt_pkg, srt_ctrl, srt_dp (and srt_ram through srt_dp).
//
// Holds up to CAPACITY records (title, name, year) sorted on the field picked
// by the key register (0 title, 1 name, 2 or 3 year). One item in, one item
// out, in order. Items are handled one at a time:
//   clear, stage, unused opcodes and an insert into a full table go from decode to finish;
//   insert: scans the entries in order, comparing up to c chars per entry (1 for
//     year), then shifts each entry from the insert position up one row, MAXC
//     chars per entry, and writes the staged record, where MAXC is the longer of
//     TITLE_CHARS and NAME_CHARS;
//   search: a binary search comparing up to c chars per probe, at most
//     log2(count)+1 probes.
// Cost is set by the single read port of each table RAM: one character of a
// stored entry is fetched per compare step, and a shift reads and then writes
// one character of each string per step. A new item is taken while the previous
// result still waits in the output register; the block holds its finished
// result until that register frees. The key register may be written at any
// time the block is idle.
module sorted_record_table #(
    parameter int CAPACITY    = srt_pkg::CAPACITY_DEF,
    parameter int TITLE_CHARS = srt_pkg::TITLE_CHARS_DEF,
    parameter int NAME_CHARS  = srt_pkg::NAME_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  srt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output srt_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata
);

    srt_pkg::t_cmd      cmd;
    srt_pkg::t_dp_stat  stat;
    srt_pkg::t_out_item result;
    logic               out_load;
    logic               out_free;
    logic               r_out_valid;
    srt_pkg::t_out_item r_out_data;

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    srt_dp #(
        .CAPACITY    (CAPACITY),
        .TITLE_CHARS (TITLE_CHARS),
        .NAME_CHARS  (NAME_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_result    (result)
    );

    // output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a waiting result");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken before the first finished");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.status != srt_pkg::ST_DONE)
            |-> (r_out_data.found_index == 6'd0))
        else $error("found index set on a failed item");

endmodule

// ===== design/srt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/srt_ctrl.sv =====
// Controller state machine for the sorted record table.
// Depends on srt_pkg; drives datapath commands from datapath status.
module srt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  srt_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_load,
    output srt_pkg::t_cmd     o_cmd
);

    srt_pkg::t_state r_state;
    srt_pkg::t_state n_state;
    logic            is_search;

    assign is_search = (i_stat.opcode == srt_pkg::OP_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = srt_pkg::S_DECODE;
            end
            srt_pkg::S_DECODE: begin
                if (i_stat.opcode == srt_pkg::OP_INSERT) begin
                    n_state = i_stat.full ? srt_pkg::S_FINISH : srt_pkg::S_SCAN_CHK;
                end else if (is_search) begin
                    n_state = srt_pkg::S_SCH_CHK;
                end else begin
                    n_state = srt_pkg::S_FINISH;
                end
            end
            srt_pkg::S_SCAN_CHK: begin
                n_state = i_stat.scan_end ? srt_pkg::S_MOVE_CHK : srt_pkg::S_CMP_EV;
            end
            srt_pkg::S_SCH_CHK: begin
                n_state = i_stat.range_empty ? srt_pkg::S_FINISH : srt_pkg::S_CMP_RD;
            end
            srt_pkg::S_CMP_RD: n_state = srt_pkg::S_CMP_EV;
            srt_pkg::S_CMP_EV: begin
                if (!i_stat.cmp_done) begin
                    n_state = srt_pkg::S_CMP_RD;
                end else if (is_search) begin
                    n_state = i_stat.cmp_eq ? srt_pkg::S_FINISH : srt_pkg::S_SCH_CHK;
                end else begin
                    n_state = (i_stat.cmp_lt || i_stat.cmp_eq) ? srt_pkg::S_SCAN_CHK
                                                               : srt_pkg::S_MOVE_CHK;
                end
            end
            srt_pkg::S_MOVE_CHK: begin
                n_state = i_stat.move_done ? srt_pkg::S_STORE : srt_pkg::S_MOVE_RD;
            end
            srt_pkg::S_MOVE_RD: n_state = srt_pkg::S_MOVE_WR;
            srt_pkg::S_MOVE_WR: begin
                n_state = i_stat.char_last ? srt_pkg::S_MOVE_CHK : srt_pkg::S_MOVE_RD;
            end
            srt_pkg::S_STORE: begin
                if (i_stat.char_last) n_state = srt_pkg::S_FINISH;
            end
            srt_pkg::S_FINISH: begin
                if (i_out_free) n_state = srt_pkg::S_IDLE;
            end
            default: n_state = srt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd      = srt_pkg::C_NONE;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = srt_pkg::C_CAPTURE;
            end
            srt_pkg::S_DECODE: begin
                if (i_stat.opcode == srt_pkg::OP_INSERT) begin
                    o_cmd = i_stat.full ? srt_pkg::C_SET_FULL : srt_pkg::C_SCAN_INIT;
                end else if (is_search) begin
                    o_cmd = srt_pkg::C_SCH_INIT;
                end else begin
                    o_cmd = srt_pkg::C_SIMPLE;
                end
            end
            srt_pkg::S_SCAN_CHK: begin
                o_cmd = i_stat.scan_end ? srt_pkg::C_MOVE_INIT : srt_pkg::C_CMP_READ;
            end
            srt_pkg::S_SCH_CHK: begin
                o_cmd = i_stat.range_empty ? srt_pkg::C_SET_MISS : srt_pkg::C_SCH_MID;
            end
            srt_pkg::S_CMP_RD: o_cmd = srt_pkg::C_CMP_READ;
            srt_pkg::S_CMP_EV: begin
                if (!i_stat.cmp_done) begin
                    o_cmd = srt_pkg::C_CHAR_NEXT;
                end else if (is_search) begin
                    if (i_stat.cmp_eq)      o_cmd = srt_pkg::C_SET_HIT;
                    else if (i_stat.cmp_lt) o_cmd = srt_pkg::C_SCH_LEFT;
                    else                    o_cmd = srt_pkg::C_SCH_RIGHT;
                end else begin
                    o_cmd = (i_stat.cmp_lt || i_stat.cmp_eq) ? srt_pkg::C_SCAN_NEXT
                                                             : srt_pkg::C_MOVE_INIT;
                end
            end
            srt_pkg::S_MOVE_CHK: o_cmd = srt_pkg::C_NONE;
            srt_pkg::S_MOVE_RD:  o_cmd = srt_pkg::C_MOVE_READ;
            srt_pkg::S_MOVE_WR:  o_cmd = srt_pkg::C_MOVE_WRITE;
            srt_pkg::S_STORE:    o_cmd = srt_pkg::C_STORE_WRITE;
            srt_pkg::S_FINISH:   o_out_load = i_out_free;
            default:             o_cmd = srt_pkg::C_NONE;
        endcase
    end

endmodule

// ===== design/srt_dp.sv =====
// Datapath for the sorted record table: table RAMs, staged record,
// search and scan counters, key comparator. Depends on srt_pkg, srt_ram.
module srt_dp #(
    parameter int CAPACITY    = srt_pkg::CAPACITY_DEF,
    parameter int TITLE_CHARS = srt_pkg::TITLE_CHARS_DEF,
    parameter int NAME_CHARS  = srt_pkg::NAME_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srt_pkg::t_cmd      i_cmd,
    input  srt_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    output srt_pkg::t_dp_stat  o_stat,
    output srt_pkg::t_out_item o_result
);

    localparam int MAXC = (TITLE_CHARS > NAME_CHARS) ? TITLE_CHARS : NAME_CHARS;
    localparam int KW   = (MAXC > 1) ? $clog2(MAXC) : 1;
    localparam int TIW  = (TITLE_CHARS > 1) ? $clog2(TITLE_CHARS) : 1;
    localparam int NIW  = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int TAW  = $clog2(CAPACITY * TITLE_CHARS);
    localparam int NAW  = $clog2(CAPACITY * NAME_CHARS);

    srt_pkg::t_in_item r_item;
    logic [1:0]        r_key;
    logic [7:0]        r_stg_title [TITLE_CHARS];
    logic [7:0]        r_stg_name  [NAME_CHARS];
    logic [15:0]       r_stg_year;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_src;
    logic [KW-1:0]     r_char;
    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_right;
    logic [1:0]        r_status;
    logic [IW-1:0]     r_hit;

    logic [IW-1:0]     rd_row;
    logic [IW-1:0]     src_m1;
    logic              ram_re;
    logic [TAW-1:0]    t_raddr, t_waddr;
    logic [NAW-1:0]    n_raddr, n_waddr;
    logic              t_we, n_we, y_we;
    logic [IW-1:0]     wr_row;
    logic [7:0]        t_wdata, n_wdata;
    logic [15:0]       y_wdata;
    logic [7:0]        t_rdata, n_rdata;
    logic [15:0]       y_rdata;
    logic signed [SW:0] mid_sum;
    logic [IW-1:0]     mid;
    logic              key_title, key_name;
    logic [7:0]        cmp_a, cmp_b;
    logic              str_last;
    logic              char_last;

    assign src_m1  = IW'(r_src - IW'(1));
    assign mid_sum = (SW + 1)'(r_left) + (SW + 1)'(r_right);
    assign mid     = IW'(mid_sum >>> 1);

    always_comb begin
        rd_row = r_idx;
        ram_re = 1'b0;
        t_we   = 1'b0;
        n_we   = 1'b0;
        y_we   = 1'b0;
        wr_row = r_src;
        t_wdata = t_rdata;
        n_wdata = n_rdata;
        y_wdata = y_rdata;
        case (i_cmd)
            srt_pkg::C_CMP_READ: ram_re = 1'b1;
            srt_pkg::C_MOVE_READ: begin
                ram_re = 1'b1;
                rd_row = src_m1;
            end
            srt_pkg::C_MOVE_WRITE: begin
                t_we = (32'(r_char) < TITLE_CHARS);
                n_we = (32'(r_char) < NAME_CHARS);
                y_we = (r_char == '0);
            end
            srt_pkg::C_STORE_WRITE: begin
                wr_row  = r_idx;
                t_we    = (32'(r_char) < TITLE_CHARS);
                n_we    = (32'(r_char) < NAME_CHARS);
                y_we    = (r_char == '0);
                t_wdata = r_stg_title[r_char[TIW-1:0]];
                n_wdata = r_stg_name[r_char[NIW-1:0]];
                y_wdata = r_stg_year;
            end
            default: ;
        endcase
    end

    assign t_raddr = TAW'(TAW'(rd_row) * TAW'(TITLE_CHARS)) + TAW'(r_char);
    assign n_raddr = NAW'(NAW'(rd_row) * NAW'(NAME_CHARS)) + NAW'(r_char);
    assign t_waddr = TAW'(TAW'(wr_row) * TAW'(TITLE_CHARS)) + TAW'(r_char);
    assign n_waddr = NAW'(NAW'(wr_row) * NAW'(NAME_CHARS)) + NAW'(r_char);

    srt_ram #(.WIDTH(8), .DEPTH(CAPACITY * TITLE_CHARS)) u_titles (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_re(ram_re), .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    srt_ram #(.WIDTH(8), .DEPTH(CAPACITY * NAME_CHARS)) u_names (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_re(ram_re), .i_raddr(n_raddr), .o_rdata(n_rdata)
    );

    srt_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_years (
        .i_clk(i_clk), .i_we(y_we), .i_waddr(wr_row), .i_wdata(y_wdata),
        .i_re(ram_re), .i_raddr(rd_row), .o_rdata(y_rdata)
    );

    // key compare: stored entry against staged record, one char per step
    assign key_title = (r_key == srt_pkg::KEY_TITLE);
    assign key_name  = (r_key == srt_pkg::KEY_NAME);
    assign cmp_a     = key_title ? t_rdata : n_rdata;
    assign cmp_b     = key_title ? r_stg_title[r_char[TIW-1:0]]
                                 : r_stg_name[r_char[NIW-1:0]];
    assign str_last  = key_title ? (32'(r_char) == TITLE_CHARS - 1)
                                 : (32'(r_char) == NAME_CHARS - 1);
    assign char_last = (32'(r_char) == MAXC - 1);

    always_comb begin
        o_stat             = '0;
        o_stat.opcode      = r_item.opcode;
        o_stat.full        = (32'(r_count) >= CAPACITY);
        o_stat.scan_end    = (CW'(r_idx) == r_count);
        o_stat.range_empty = (r_left > r_right);
        o_stat.move_done   = (r_src == r_idx);
        o_stat.char_last   = char_last;
        if (key_title || key_name) begin
            o_stat.cmp_done = (cmp_a != cmp_b) || (cmp_a == 8'd0) || str_last;
            o_stat.cmp_lt   = (cmp_a < cmp_b);
            o_stat.cmp_eq   = (cmp_a == cmp_b);
        end else begin
            o_stat.cmp_done = 1'b1;
            o_stat.cmp_lt   = (y_rdata < r_stg_year);
            o_stat.cmp_eq   = (y_rdata == r_stg_year);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= srt_pkg::KEY_YEAR;
            r_count    <= '0;
            r_stg_year <= '0;
            for (int i = 0; i < TITLE_CHARS; i++) r_stg_title[i] <= '0;
            for (int i = 0; i < NAME_CHARS; i++)  r_stg_name[i]  <= '0;
        end else begin
            if (i_cfg_we) r_key <= i_cfg_wdata;
            case (i_cmd)
                srt_pkg::C_SIMPLE: begin
                    case (r_item.opcode)
                        srt_pkg::OP_CLEAR: begin
                            r_count    <= '0;
                            r_stg_year <= '0;
                            for (int i = 0; i < TITLE_CHARS; i++) r_stg_title[i] <= '0;
                            for (int i = 0; i < NAME_CHARS; i++)  r_stg_name[i]  <= '0;
                        end
                        srt_pkg::OP_STAGE_TITLE: begin
                            if (32'(r_item.char_position) < TITLE_CHARS)
                                r_stg_title[TIW'(r_item.char_position)] <=
                                    r_item.char_value;
                        end
                        srt_pkg::OP_STAGE_NAME: begin
                            if (32'(r_item.char_position) < NAME_CHARS)
                                r_stg_name[NIW'(r_item.char_position)] <=
                                    r_item.char_value;
                        end
                        srt_pkg::OP_STAGE_YEAR: r_stg_year <= r_item.year_value;
                        default: ;
                    endcase
                end
                srt_pkg::C_STORE_WRITE: begin
                    if (char_last) r_count <= CW'(r_count + CW'(1));
                end
                default: ;
            endcase
        end
    end

    // item, counters and result fields; no reset needed
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            srt_pkg::C_CAPTURE: begin
                r_item   <= i_item;
                r_status <= srt_pkg::ST_DONE;
                r_hit    <= '0;
                r_char   <= '0;
            end
            srt_pkg::C_SCAN_INIT: begin
                r_idx  <= '0;
                r_char <= '0;
            end
            srt_pkg::C_SCAN_NEXT: begin
                r_idx  <= IW'(r_idx + IW'(1));
                r_char <= '0;
            end
            srt_pkg::C_SCH_INIT: begin
                r_left  <= '0;
                r_right <= SW'($signed({1'b0, r_count}) - SW'(1));
            end
            srt_pkg::C_SCH_MID: begin
                r_idx  <= mid;
                r_char <= '0;
            end
            srt_pkg::C_SCH_LEFT:  r_left  <= SW'($signed({1'b0, r_idx}) + SW'(1));
            srt_pkg::C_SCH_RIGHT: r_right <= SW'($signed({1'b0, r_idx}) - SW'(1));
            srt_pkg::C_CHAR_NEXT: r_char  <= KW'(r_char + KW'(1));
            srt_pkg::C_MOVE_INIT: begin
                r_src  <= IW'(r_count);
                r_char <= '0;
            end
            srt_pkg::C_MOVE_WRITE: begin
                if (char_last) begin
                    r_src  <= src_m1;
                    r_char <= '0;
                end else begin
                    r_char <= KW'(r_char + KW'(1));
                end
            end
            srt_pkg::C_STORE_WRITE: r_char <= char_last ? '0 : KW'(r_char + KW'(1));
            srt_pkg::C_SET_FULL:    r_status <= srt_pkg::ST_FULL;
            srt_pkg::C_SET_MISS:    r_status <= srt_pkg::ST_NOT_FOUND;
            srt_pkg::C_SET_HIT:     r_hit    <= r_idx;
            default: ;
        endcase
    end

    assign o_result.status      = r_status;
    assign o_result.found_index = 6'(r_hit);
    assign o_result.entry_total = 7'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count beyond capacity");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == srt_pkg::C_STORE_WRITE) |-> (32'(r_count) < CAPACITY))
        else $error("store into a full table");

    a_move_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == srt_pkg::C_MOVE_WRITE) |-> (r_src > r_idx))
        else $error("shift below insert position");

    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == srt_pkg::C_SET_HIT) |-> (CW'(r_idx) < r_count))
        else $error("search hit outside held entries");

endmodule
